FILE: rtl/assert_macros.svh
// Assertion helpers for RTL files that check themselves; the top evaluator unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

`endif

FILE: rtl/pie_pkg.sv
`default_nettype none
package pie_pkg;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    // Command kinds passed from the tokenizer to the executor.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_OP   = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/postfix_integer_evaluator_unit.sv
`default_nettype none
// A newline result passes the command queue, then the executor's TOP and OUT states;
// operators run through RD1, RD2, EXEC and DIV, where divide and modulo wait on the
// shift-subtract divider. Throughput: one byte per cycle while the command queue has room;
// the stack RAM's single read port sets the operator cost. Reset: synchronous active-low
// clears control state and counts; the stack RAM is not cleared.
module postfix_integer_evaluator_unit #(
    parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = pie_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_text_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_result_value,
    output logic [2:0]              m_status
);
    import pie_pkg::*;
    `include "assert_macros.svh"

    localparam int QW = 2 + 8 + DATA_WIDTH + 1;

    logic                  f_valid, f_ready, q_valid, q_ready;
    logic [1:0]            f_kind;
    logic [7:0]            f_op;
    logic [DATA_WIDTH-1:0] f_value;
    logic [QW-1:0]         q_data;

    pie_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_byte(s_text_byte),
        .cmd_valid(f_valid), .cmd_ready(f_ready),
        .cmd_kind(f_kind), .cmd_op(f_op), .cmd_value(f_value)
    );

    // The last flag marks the command issued by a newline.
    pie_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data({f_kind, f_op, f_value, s_text_byte == CH_LF}),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    pie_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready),
        .cmd_kind(q_data[QW-1 -: 2]), .cmd_op(q_data[QW-3 -: 8]),
        .cmd_value(q_data[DATA_WIDTH:1]), .cmd_last(q_data[0]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_value(m_result_value), .m_status(m_status)
    );

    // A result's status holds steady while stalled.
    `ASSERT_IMPL(a_out_hold, aclk, aresetn, m_valid && !m_ready, ##1 $stable(m_status))
    // Status never carries a code beyond unknown operator.
    `ASSERT_ALWAYS(a_status_range, aclk, aresetn, !m_valid || m_status <= ST_UNKNOWN)
endmodule
`default_nettype wire

FILE: rtl/pie_front.sv
`default_nettype none
// Tokenizer: turns text bytes into push, operator and end commands.
module pie_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            in_byte,
    output logic                       cmd_valid,
    input  wire logic                  cmd_ready,
    output logic [1:0]                 cmd_kind,
    output logic [7:0]                 cmd_op,
    output logic [DATA_WIDTH-1:0]      cmd_value
);
    import pie_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MINUS  = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;
    localparam logic [1:0] MODE_TAIL   = 2'd3;

    logic [1:0]            mode_reg, mode_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [7:0]            pend_reg, pend_next;
    logic                  is_dig, fire;
    logic [DATA_WIDTH-1:0] digit, num;

    // A byte that ends a token issues one command, so it needs a free slot.
    assign in_ready = cmd_ready;
    assign fire     = in_valid && in_ready;
    assign is_dig   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = DATA_WIDTH'(in_byte - CH_ZERO);
    assign num      = neg_reg ? (~acc_reg + 1'b1) : acc_reg;

    // Token classification and command generation.
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        pend_next = pend_reg;
        cmd_valid = 1'b0;
        cmd_kind  = CMD_PUSH;
        cmd_op    = pend_reg;
        cmd_value = num;
        if (fire && (in_byte == CH_LF || in_byte == CH_SPACE)) begin
            unique case (mode_reg)
                MODE_MINUS: begin
                    cmd_kind = CMD_OP;
                    cmd_op   = CH_MINUS;
                end
                MODE_TAIL: cmd_kind = (pend_reg == CH_ZERO) ? CMD_PUSH : CMD_OP;
                default: cmd_kind = CMD_PUSH;
            endcase
            cmd_valid = (mode_reg != MODE_IDLE);
            if (in_byte == CH_LF) begin
                // End command carries the last token inline.
                cmd_valid = 1'b1;
                if (mode_reg == MODE_IDLE) cmd_kind = CMD_END;
            end
            mode_next = MODE_IDLE;
            acc_next  = '0;
            neg_next  = 1'b0;
            pend_next = 8'd0;
        end else if (fire) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (is_dig) begin
                        acc_next  = digit;
                        neg_next  = 1'b0;
                        mode_next = MODE_DIGITS;
                    end else if (in_byte == CH_MINUS) begin
                        mode_next = MODE_MINUS;
                    end else begin
                        pend_next = in_byte;
                        mode_next = MODE_TAIL;
                    end
                end
                MODE_MINUS: begin
                    if (is_dig) begin
                        acc_next  = digit;
                        neg_next  = 1'b1;
                        mode_next = MODE_DIGITS;
                    end else begin
                        pend_next = CH_MINUS;
                        mode_next = MODE_TAIL;
                    end
                end
                MODE_DIGITS: begin
                    if (is_dig) begin
                        acc_next = DATA_WIDTH'((acc_reg << 3) + (acc_reg << 1)) + digit;
                    end else begin
                        pend_next = CH_ZERO;
                        mode_next = MODE_TAIL;
                    end
                end
                default: mode_next = MODE_TAIL;
            endcase
        end
    end

    // The final token of a line is flagged by the last bit that the top level adds on a newline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            pend_reg <= 8'd0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            pend_reg <= pend_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pie_queue.sv
`default_nettype none
// Small command FIFO between tokenizer and executor.
module pie_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             wr, rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pie_divider.sv
`default_nettype none
// Restoring divider on magnitudes, one quotient bit per cycle.
module pie_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient,
    output logic [DATA_WIDTH-1:0]      remainder
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] q_reg, d_reg, r_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic [DATA_WIDTH:0]   trial;

    assign trial     = {r_reg, q_reg[DATA_WIDTH-1]} - {1'b0, d_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = busy_reg && (cnt_reg == '0);

    // One shift-subtract step per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DATA_WIDTH);
            q_reg    <= dividend;
            d_reg    <= divisor;
            r_reg    <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!trial[DATA_WIDTH]) begin
                    r_reg <= trial[DATA_WIDTH-1:0];
                    q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[DATA_WIDTH-2:0], q_reg[DATA_WIDTH-1]};
                    q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pie_back.sv
`default_nettype none
// Executor: owns the operand stack and carries out commands.
module pie_back #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire logic [1:0]            cmd_kind,
    input  wire logic [7:0]            cmd_op,
    input  wire logic [DATA_WIDTH-1:0] cmd_value,
    input  wire logic                  cmd_last,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_result_value,
    output logic [2:0]                 m_status
);
    import pie_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD1   = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_TOP   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg, a_reg, b_reg;
    logic [CW-1:0]         cnt_reg;
    logic [2:0]            state_reg, sticky_reg;
    logic [7:0]            op_reg;
    logic                  last_reg;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  div_start, div_done;
    logic [DATA_WIDTH-1:0] ma, mb, dq, dr, prod;
    logic                  sa, sb;

    assign sa = a_reg[DATA_WIDTH-1];
    assign sb = b_reg[DATA_WIDTH-1];
    assign ma = sa ? (~a_reg + 1'b1) : a_reg;
    assign mb = sb ? (~b_reg + 1'b1) : b_reg;
    assign prod = DATA_WIDTH'(a_reg * b_reg);

    pie_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(ma), .divisor(mb), .done(div_done),
        .quotient(dq), .remainder(dr)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign div_start = (state_reg == S_EXEC) && (op_reg == CH_SLASH || op_reg == CH_PCT)
                       && (b_reg != '0);

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) stack_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= stack_mem[rd_addr];
    end

    // Sequencer for push, operator and end-of-line work.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            sticky_reg <= ST_OK;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        op_reg   <= cmd_op;
                        last_reg <= cmd_last;
                        if (cmd_kind == CMD_PUSH) begin
                            if (cnt_reg == CW'(STACK_DEPTH)) begin
                                if (sticky_reg == ST_OK) sticky_reg <= ST_OVER;
                            end else begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            state_reg <= cmd_last ? S_TOP : S_IDLE;
                        end else if (cmd_kind == CMD_OP) begin
                            if (cnt_reg < CW'(2)) begin
                                if (sticky_reg == ST_OK) sticky_reg <= ST_UNDER;
                                cnt_reg   <= CW'(1);
                                state_reg <= cmd_last ? S_TOP : S_IDLE;
                            end else begin
                                state_reg <= S_RD1;
                            end
                        end else begin
                            state_reg <= S_TOP;
                        end
                    end
                end
                S_RD1: begin
                    b_reg     <= rd_data_reg;
                    state_reg <= S_RD2;
                end
                S_RD2: begin
                    a_reg     <= rd_data_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (!(op_reg == CH_SLASH || op_reg == CH_PCT) || b_reg == '0 || div_done)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (sticky_reg == ST_OK) begin
                            if ((op_reg == CH_SLASH || op_reg == CH_PCT) && b_reg == '0)
                                sticky_reg <= ST_DIVZERO;
                            else if (!(op_reg == CH_PLUS || op_reg == CH_STAR ||
                                       op_reg == CH_MINUS || op_reg == CH_AMP ||
                                       op_reg == CH_BAR || op_reg == CH_CARET ||
                                       op_reg == CH_SLASH || op_reg == CH_PCT))
                                sticky_reg <= ST_UNKNOWN;
                        end
                        state_reg <= last_reg ? S_TOP : S_IDLE;
                    end
                end
                S_TOP: state_reg <= S_OUT;
                S_OUT: begin
                    if (m_ready) begin
                        state_reg  <= S_IDLE;
                        cnt_reg    <= '0;
                        sticky_reg <= ST_OK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Operator result from the two popped operands; divide and modulo use the divider.
    logic [DATA_WIDTH-1:0] alu_r;
    logic                  alu_ok;
    always_comb begin
        alu_ok = 1'b1;
        alu_r  = '0;
        case (op_reg)
            CH_PLUS:  alu_r = a_reg + b_reg;
            CH_STAR:  alu_r = prod;
            CH_MINUS: alu_r = a_reg - b_reg;
            CH_AMP:   alu_r = a_reg & b_reg;
            CH_BAR:   alu_r = a_reg | b_reg;
            CH_CARET: alu_r = a_reg ^ b_reg;
            CH_SLASH: alu_r = (sa != sb) ? (~dq + 1'b1) : dq;
            CH_PCT:   alu_r = sa ? (~dr + 1'b1) : dr;
            default:  alu_ok = 1'b0;
        endcase
        if (!alu_ok || ((op_reg == CH_SLASH || op_reg == CH_PCT) && b_reg == '0))
            alu_r = '0;
    end

    // Memory port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = cmd_value;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && cmd_kind == CMD_PUSH && cnt_reg != CW'(STACK_DEPTH)) begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg[AW-1:0];
                end else if (cmd_valid && cmd_kind == CMD_OP && cnt_reg < CW'(2)) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = '0;
                end else if (cmd_valid && cmd_kind == CMD_OP) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(cnt_reg - 1'b1);
                end
            end
            S_RD1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(cnt_reg - CW'(2));
            end
            S_DIV: begin
                wr_en   = !(op_reg == CH_SLASH || op_reg == CH_PCT) || b_reg == '0 || div_done;
                wr_addr = AW'(cnt_reg - CW'(2));
                wr_data = alu_r;
            end
            S_TOP: begin
                rd_en   = (cnt_reg != '0);
                rd_addr = AW'(cnt_reg - 1'b1);
            end
            default: ;
        endcase
    end

    // Output value, sign-extended from the stack width.
    always_comb begin
        if (cnt_reg == '0) begin
            m_result_value = '0;
            m_status       = (sticky_reg == ST_OK) ? ST_UNDER : sticky_reg;
        end else begin
            m_result_value = 32'($signed(rd_data_reg));
            m_status       = sticky_reg;
        end
    end
endmodule
`default_nettype wire

FILE: tb/postfix_integer_evaluator_unit_tb.sv
`default_nettype none
module postfix_integer_evaluator_unit_tb;
    import pie_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = pie_pkg::STACK_DEPTH_DEF;
    localparam int N_ITEMS = 550;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_text_byte = 8'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_result_value;
    logic [2:0] m_status;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } eval_result_t;

    typedef enum logic [1:0] {
        TOK_IDLE   = 2'd0,
        TOK_MINUS  = 2'd1,
        TOK_DIGITS = 2'd2,
        TOK_TAIL   = 2'd3
    } tok_mode_t;

    // Expression text for the directed part; the known result is checked as well
    // when has_known is set.
    typedef struct {
        string       text;
        bit          has_known;
        logic [31:0] known_value;
        logic [2:0]  known_status;
    } directed_row_t;

    postfix_integer_evaluator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_text_byte(s_text_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_value(m_result_value), .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [31:0] stk [DEPTH];
    int          stk_count;
    logic [31:0] num_acc;
    tok_mode_t   tok_mode;
    bit          neg_flag;
    logic [7:0]  pend_op;
    logic [2:0]  sticky;

    eval_result_t expected_results[$];
    eval_result_t known_results[$];
    bit           known_flags[$];
    int           error_count = 0;
    int           sent_items = 0;
    bit           hold_receiver = 1'b0;

    function automatic void clear_eval();
        stk_count = 0;
        num_acc = '0;
        tok_mode = TOK_IDLE;
        neg_flag = 1'b0;
        pend_op = '0;
        sticky = ST_OK;
    endfunction

    function automatic void flag_error(logic [2:0] code);
        if (sticky == ST_OK) sticky = code;
    endfunction

    function automatic void push_operand(logic [31:0] v);
        if (stk_count >= DEPTH) begin
            flag_error(ST_OVER);
            return;
        end
        stk[stk_count] = v;
        stk_count++;
    endfunction

    function automatic void apply_op(logic [7:0] op);
        logic [31:0] a, b, r, ma, mb;
        logic [2:0] err;
        r = '0;
        err = ST_OK;
        if (stk_count < 2) begin
            stk_count = 0;
            flag_error(ST_UNDER);
            push_operand('0);
            return;
        end
        b = stk[stk_count-1];
        a = stk[stk_count-2];
        stk_count -= 2;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (op)
            CH_PLUS:  r = a + b;
            CH_STAR:  r = a * b;
            CH_MINUS: r = a - b;
            CH_AMP:   r = a & b;
            CH_BAR:   r = a | b;
            CH_CARET: r = a ^ b;
            CH_SLASH, CH_PCT: begin
                if (b == 0) begin
                    err = ST_DIVZERO;
                end else if (op == CH_SLASH) begin
                    r = ma / mb;
                    if (a[31] != b[31]) r = -r;
                end else begin
                    r = ma % mb;
                    if (a[31]) r = -r;
                end
            end
            default: err = ST_UNKNOWN;
        endcase
        if (err != ST_OK) begin
            flag_error(err);
            r = '0;
        end
        push_operand(r);
    endfunction

    function automatic void close_token();
        logic [31:0] v;
        v = neg_flag ? -num_acc : num_acc;
        case (tok_mode)
            TOK_MINUS:  apply_op(CH_MINUS);
            TOK_DIGITS: push_operand(v);
            TOK_TAIL:   if (pend_op == CH_ZERO) push_operand(v); else apply_op(pend_op);
            default: ;
        endcase
        tok_mode = TOK_IDLE;
        num_acc = '0;
        neg_flag = 1'b0;
        pend_op = '0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Advances the evaluator by one character; returns 1 with a result at newline.
    function automatic bit evaluate_char(logic [7:0] c, output eval_result_t res);
        res = '0;
        if (c == CH_LF) begin
            close_token();
            if (stk_count == 0) flag_error(ST_UNDER);
            else res.value = stk[stk_count-1];
            res.status = sticky;
            clear_eval();
            return 1'b1;
        end
        if (c == CH_SPACE) begin
            close_token();
            return 1'b0;
        end
        case (tok_mode)
            TOK_IDLE: begin
                if (is_digit(c)) begin
                    num_acc = 32'(c - CH_ZERO);
                    neg_flag = 1'b0;
                    tok_mode = TOK_DIGITS;
                end else if (c == CH_MINUS) begin
                    tok_mode = TOK_MINUS;
                end else begin
                    pend_op = c;
                    tok_mode = TOK_TAIL;
                end
            end
            TOK_MINUS: begin
                if (is_digit(c)) begin
                    num_acc = 32'(c - CH_ZERO);
                    neg_flag = 1'b1;
                    tok_mode = TOK_DIGITS;
                end else begin
                    pend_op = CH_MINUS;
                    tok_mode = TOK_TAIL;
                end
            end
            TOK_DIGITS: begin
                if (is_digit(c)) begin
                    num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
                end else begin
                    pend_op = CH_ZERO;
                    tok_mode = TOK_TAIL;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Sends one character, sometimes idling first, and records the predicted result at a newline.
    task automatic send_char(logic [7:0] c, bit has_known, eval_result_t known);
        eval_result_t res;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= c;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        if (evaluate_char(c, res)) begin
            expected_results.push_back(res);
            known_results.push_back(known);
            known_flags.push_back(has_known);
        end
    endtask

    task automatic send_text(string text, bit has_known, eval_result_t known);
        for (int i = 0; i < text.len(); i++) send_char(text[i], has_known, known);
    endtask

    function automatic string rand_number();
        string s;
        int n;
        s = ($urandom_range(0, 3) == 0) ? "-" : "";
        n = $urandom_range(1, 11);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_operator();
        logic [7:0] ops [8] = '{CH_PLUS, CH_STAR, CH_MINUS, CH_SLASH,
                                CH_AMP, CH_BAR, CH_PCT, CH_CARET};
        return string'(ops[$urandom_range(0, 7)]);
    endfunction

    // Well-formed postfix with random content, occasionally broken or noisy.
    function automatic string rand_expression();
        string s;
        int depth_now, n_tok;
        logic [7:0] noise;
        s = "";
        depth_now = 0;
        n_tok = $urandom_range(1, 9);
        for (int i = 0; i < n_tok; i++) begin
            if (depth_now >= 2 && $urandom_range(0, 1) == 0) begin
                s = {s, rand_operator()};
                depth_now--;
            end else begin
                s = {s, rand_number()};
                depth_now++;
            end
            if ($urandom_range(0, 9) == 0) begin
                noise = 8'($urandom_range(0, 255));
                if (noise != CH_LF && noise != CH_SPACE) s = {s, string'(noise)};
            end
            s = {s, ($urandom_range(0, 7) == 0) ? "  " : " "};
        end
        while (depth_now > 1 && $urandom_range(0, 4) != 0) begin
            s = {s, rand_operator(), " "};
            depth_now--;
        end
        return {s, "\n"};
    endfunction

    // Receiver with random stalls.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            if (hold_receiver) begin
                m_ready <= 1'b0;
                while (hold_receiver) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Long receiver hold-off, counted here, while the sender keeps offering bytes into back-pressure.
    initial begin
        @(posedge aclk iff aresetn);
        repeat (200) @(posedge aclk);
        hold_receiver = 1'b1;
        repeat (500) @(posedge aclk);
        hold_receiver = 1'b0;
    end

    // Result checker.
    always @(posedge aclk) begin
        eval_result_t exp_res, known;
        bit has_known;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d",
                         $time, m_result_value, m_status);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                known = known_results.pop_front();
                has_known = known_flags.pop_front();
                if (has_known && known != exp_res) begin
                    $display("%0t: table row expected %h/%0d, predictor %h/%0d", $time,
                             known.value, known.status, exp_res.value, exp_res.status);
                    error_count++;
                end
                if (m_result_value !== exp_res.value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, exp_res.value, m_result_value);
                    error_count++;
                end
                if (m_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, m_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("postfix_integer_evaluator_unit_tb: errors");
        $finish;
    end

    // Stimulus.
    initial begin
        directed_row_t rows[$];
        eval_result_t known;
        string deep;
        rows = '{
            '{"\n", 1, 32'd0, ST_UNDER},
            '{"   \n", 1, 32'd0, ST_UNDER},
            '{"2147483647\n", 1, 32'h7FFFFFFF, ST_OK},
            '{"-2147483648\n", 1, 32'h80000000, ST_OK},
            '{"0 \n", 1, 32'd0, ST_OK},
            '{"4294967296\n", 1, 32'd0, ST_OK},
            '{"7 0 /\n", 1, 32'd0, ST_DIVZERO},
            '{"7 0 %\n", 1, 32'd0, ST_DIVZERO},
            '{"3 4 #\n", 1, 32'd0, ST_UNKNOWN},
            '{"+\n", 1, 32'd0, ST_UNDER},
            '{"-2147483648 -1 /\n", 1, 32'h80000000, ST_OK},
            '{"-2147483648 -1 %\n", 1, 32'd0, ST_OK},
            '{"12 5 +\n", 0, 0, 0},
            '{"12 5 -\n", 0, 0, 0},
            '{"12 5 *\n", 0, 0, 0},
            '{"-7 2 /\n", 0, 0, 0},
            '{"-7 2 %\n", 0, 0, 0},
            '{"12 10 & 3 | 5 ^\n", 0, 0, 0},
            '{"5 3 -xyz\n", 0, 0, 0},
            '{"12ab 3 +\n", 0, 0, 0},
            '{"\t5 \r 8\000 +\n", 0, 0, 0},
            '{"1 0 / 5 #\n", 0, 0, 0},
            '{"-- 4\n", 0, 0, 0}
        };
        s_valid <= 1'b0;
        s_text_byte <= '0;
        clear_eval();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            known.value = rows[i].known_value;
            known.status = rows[i].known_status;
            send_text(rows[i].text, rows[i].has_known, known);
        end
        // Stack overflow: one more number than the stack holds.
        deep = "";
        for (int i = 0; i <= DEPTH; i++) deep = {deep, "9 "};
        send_text({deep, "\n"}, 1'b1, '{value: 32'd9, status: ST_OVER});
        // A spread of byte values across the whole range, as token content.
        for (int c = 0; c < 256; c += 3)
            if (c != CH_LF) send_char(8'(c), 1'b0, '0);
        send_char(CH_LF, 1'b0, '0);
        while (sent_items < N_ITEMS) send_text(rand_expression(), 1'b0, '0);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("postfix_integer_evaluator_unit_tb: clean");
        end else begin
            $display("postfix_integer_evaluator_unit_tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
